/* design/sad_pkg.sv */
// Shared codes and control types for the shifting array deque.
// No dependencies; imported by every module of the block.
package sad_pkg;

	localparam int DEPTH_DEF = 8;

	localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
	localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
	localparam logic [1:0] REQ_POP_REAR   = 2'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [2:0] OP_NONE       = 3'd0;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [2:0] OP_PUSH_REAR  = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_POP_REAR   = 3'd4;

	typedef struct packed {
		logic       load;
		logic       exec;
		logic [2:0] op;
		logic [1:0] st;
	} sad_cmd_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] req_type;
	} sad_stat_t;

endpackage

/* design/sad_ctrl.sv */
// Controller for the shifting array deque: handshakes and request decode.
// Depends on sad_pkg; drives the datapath through sad_cmd_t.
module sad_ctrl
	import sad_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  sad_stat_t stat,
	output sad_cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = in_valid && !in_stall;
		cmd.exec = (state_q == S_RUN);
		cmd.op   = OP_NONE;
		cmd.st   = ST_DONE;
		case (stat.req_type)
			REQ_PUSH_FRONT: begin
				if (stat.full) cmd.st = ST_FULL;
				else           cmd.op = OP_PUSH_FRONT;
			end
			REQ_PUSH_REAR: begin
				if (stat.full) cmd.st = ST_FULL;
				else           cmd.op = OP_PUSH_REAR;
			end
			REQ_POP_FRONT: begin
				if (stat.empty) cmd.st = ST_EMPTY;
				else            cmd.op = OP_POP_FRONT;
			end
			REQ_POP_REAR: begin
				if (stat.empty) cmd.st = ST_EMPTY;
				else            cmd.op = OP_POP_REAR;
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_RUN;
				end
				S_RUN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_RUN)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* design/sad_datapath.sv */
// Datapath for the shifting array deque: slot registers, fill count, result registers.
// Depends on sad_pkg; commanded by sad_ctrl.
module sad_datapath
	import sad_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sad_cmd_t           cmd,
	output sad_stat_t          stat,
	input  logic        [1:0]  req_type,
	input  logic signed [31:0] item_value,
	output logic        [1:0]  status,
	output logic        [3:0]  fill_level,
	output logic               is_empty,
	output logic               is_full,
	output logic signed [31:0] head_value,
	output logic signed [31:0] tail_value
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [31:0]   slots_q [DEPTH];
	logic [31:0]   nxt_slots [DEPTH];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] nxt_cnt;
	logic [IW-1:0] tail_idx;
	logic [1:0]    req_q;
	logic [31:0]   word_q;

	logic [1:0]    status_q;
	logic [CW-1:0] level_q;
	logic signed [31:0] head_q;
	logic signed [31:0] tail_q;

	assign stat.full     = (cnt_q == FULL_CNT);
	assign stat.empty    = (cnt_q == '0);
	assign stat.req_type = req_q;

	always_comb begin
		nxt_cnt = cnt_q;
		for (int k = 0; k < DEPTH; k++) begin
			nxt_slots[k] = slots_q[k];
		end
		case (cmd.op)
			OP_PUSH_FRONT: begin
				nxt_slots[0] = word_q;
				for (int k = 1; k < DEPTH; k++) begin
					nxt_slots[k] = slots_q[k-1];
				end
				nxt_cnt = cnt_q + CW'(1);
			end
			OP_PUSH_REAR: begin
				for (int k = 0; k < DEPTH; k++) begin
					if (cnt_q == CW'(k)) nxt_slots[k] = word_q;
				end
				nxt_cnt = cnt_q + CW'(1);
			end
			OP_POP_FRONT: begin
				for (int k = 0; k < DEPTH - 1; k++) begin
					nxt_slots[k] = slots_q[k+1];
				end
				nxt_cnt = cnt_q - CW'(1);
			end
			OP_POP_REAR: begin
				nxt_cnt = cnt_q - CW'(1);
			end
			default: begin
				nxt_cnt = cnt_q;
			end
		endcase
		tail_idx = IW'(nxt_cnt - CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec) begin
			cnt_q <= nxt_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			word_q <= item_value;
		end
		if (cmd.exec) begin
			for (int k = 0; k < DEPTH; k++) begin
				slots_q[k] <= nxt_slots[k];
			end
			status_q <= cmd.st;
			level_q  <= nxt_cnt;
			head_q   <= (nxt_cnt == '0) ? 32'sd0 : signed'(nxt_slots[0]);
			tail_q   <= (nxt_cnt == '0) ? 32'sd0 : signed'(nxt_slots[tail_idx]);
		end
	end

	assign status     = status_q;
	assign fill_level = 4'(level_q);
	assign is_empty   = (level_q == '0);
	assign is_full    = (level_q == FULL_CNT);
	assign head_value = head_q;
	assign tail_value = tail_q;

endmodule

/* design/shifting_array_deque_core.sv */
// Shifting array deque: bounded double-ended queue of signed 32-bit words.
// Depends on sad_pkg, sad_ctrl and sad_datapath.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request: req_type selects
//   push front, push rear, pop front or pop rear; item_value is the word to
//   push. Output channel (out_valid/out_stall) returns one result per request:
//   status, fill_level, is_empty, is_full, head_value and tail_value as they
//   stand after the request. Popped words are not returned.
//   A request is captured into registers, and the controller applies the slot
//   update (a parallel shift for front operations) in the cycle after; no new
//   request is taken until the result of the last one is registered.
//   A push when full or a pop when empty is rejected and changes nothing.
//   Reset empties the queue and drops any pending result; slot contents
//   are not cleared. While the receiver stalls, the result holds and
//   in_stall stays high, so at most one request is outstanding.
module shifting_array_deque_core
	import sad_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic        [1:0]  req_type,
	input  logic signed [31:0] item_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [1:0]  status,
	output logic        [3:0]  fill_level,
	output logic               is_empty,
	output logic               is_full,
	output logic signed [31:0] head_value,
	output logic signed [31:0] tail_value
);

	sad_cmd_t  cmd;
	sad_stat_t stat;

	sad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	sad_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (req_type),
		.item_value (item_value),
		.status     (status),
		.fill_level (fill_level),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.head_value (head_value),
		.tail_value (tail_value)
	);

`ifndef SYNTHESIS
	a_no_accept_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !(out_valid && out_stall))
		else $error("request taken while a result is held");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##2 out_valid)
		else $error("result missing two cycles after request");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_empty && is_full))
		else $error("empty and full both set");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_empty) |-> (head_value == 0 && tail_value == 0))
		else $error("empty queue reports nonzero words");
`endif

endmodule
